// ----- rtl/core/shd_pkg.sv -----
package shd_pkg;

  localparam logic [10:0] FIRST_YEAR = 11'd1395;
  localparam logic [10:0] LAST_YEAR  = 11'd1403;
  localparam logic [10:0] PAST_YEAR  = 11'd1404;
  localparam logic [3:0]  LAST_MONTH = 4'd12;
  localparam int unsigned NUM_HOLIDAYS = 13;

  localparam logic [3:0] HOL_MONTH [NUM_HOLIDAYS] =
    '{4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd1, 4'd3, 4'd3, 4'd11, 4'd12, 4'd12, 4'd12, 4'd12};
  localparam logic [4:0] HOL_DAY [NUM_HOLIDAYS] =
    '{5'd1, 5'd2, 5'd3, 5'd4, 5'd12, 5'd13, 5'd14, 5'd15, 5'd22, 5'd27, 5'd28, 5'd29, 5'd30};

  localparam logic [2:0] WD_THURSDAY = 3'd4;
  localparam logic [2:0] WD_FRIDAY   = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADV,
    ST_CHECK,
    ST_YEARS,
    ST_MONTHS,
    ST_COMMIT,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic accept;
    logic adv;
    logic check;
    logic year_step;
    logic month_step;
    logic commit;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic load_ok;
    logic year_done;
    logic month_done;
    logic out_busy;
  } status_t;

  // month length; leap means year mod 4 is 3
  function automatic logic [4:0] month_len(input logic leap, input logic [3:0] m);
    logic [4:0] len;
    if (m <= 4'd6) begin
      len = 5'd31;
    end else if (m <= 4'd11) begin
      len = 5'd30;
    end else begin
      len = leap ? 5'd30 : 5'd29;
    end
    return len;
  endfunction

  // sum mod 7 of a weekday and a small step
  function automatic logic [2:0] add_mod7(input logic [2:0] wd, input logic [1:0] inc);
    logic [3:0] s;
    s = {1'b0, wd} + {2'b00, inc};
    if (s >= 4'd7) begin
      s = s - 4'd7;
    end
    return s[2:0];
  endfunction

  // remainder by 7 of a value below 35
  function automatic logic [2:0] mod7_small(input logic [4:0] v);
    logic [4:0] r;
    r = v;
    if (r >= 5'd28) r = r - 5'd28;
    if (r >= 5'd14) r = r - 5'd14;
    if (r >= 5'd7)  r = r - 5'd7;
    return r[2:0];
  endfunction

  function automatic logic fixed_holiday(input logic [3:0] m, input logic [4:0] d);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NUM_HOLIDAYS; k++) begin
      if (HOL_MONTH[k] == m && HOL_DAY[k] == d) hit = 1'b1;
    end
    return hit;
  endfunction

endpackage

// ----- rtl/core/solar_hijri_date_counter.sv -----
// an advance beat goes from acceptance through the advance and emit states into the output register
// a load beat is checked; a valid one walks years, then months, and commits; both are then emitted
// a new beat is taken once the previous result sits in the output register
// reset: asynchronous active low, date 1395-01-01 Sunday, no result pending
module solar_hijri_date_counter import shd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        action_i,
  input  logic [11:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [2:0]  weekday_out_o,
  output logic        is_holiday_o,
  output logic        in_range_o,
  output logic        load_rejected_o
);

  // controller issues at most one command per cycle, datapath reports back
  cmd_t    cmd;
  status_t sts;

  // sequencer: accept, then advance or check and walk a valid load, then hand off to the output register
  shd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // date registers, mod 7 weekday accumulator and the output register
  shd_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .action_i        (action_i),
    .load_year_i     (load_year_i),
    .load_month_i    (load_month_i),
    .load_day_i      (load_day_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .year_out_o      (year_out_o),
    .month_out_o     (month_out_o),
    .day_out_o       (day_out_o),
    .weekday_out_o   (weekday_out_o),
    .is_holiday_o    (is_holiday_o),
    .in_range_o      (in_range_o),
    .load_rejected_o (load_rejected_o)
  );

endmodule

// ----- rtl/core/shd_ctrl.sv -----
module shd_ctrl import shd_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_stall_o,
  input  status_t sts_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = sts_i.action ? ST_CHECK : ST_ADV;
        end
      end
      ST_ADV: begin
        cmd_o.adv = 1'b1;
        state_d   = ST_EMIT;
      end
      ST_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = sts_i.load_ok ? ST_YEARS : ST_EMIT;
      end
      ST_YEARS: begin
        if (sts_i.year_done) begin
          state_d = ST_MONTHS;
        end else begin
          cmd_o.year_step = 1'b1;
        end
      end
      ST_MONTHS: begin
        if (sts_i.month_done) begin
          state_d = ST_COMMIT;
        end else begin
          cmd_o.month_step = 1'b1;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        state_d      = ST_EMIT;
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/core/shd_datapath.sv -----
module shd_datapath import shd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  output status_t     sts_o,
  input  logic        action_i,
  input  logic [11:0] load_year_i,
  input  logic [3:0]  load_month_i,
  input  logic [4:0]  load_day_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [10:0] year_out_o,
  output logic [3:0]  month_out_o,
  output logic [4:0]  day_out_o,
  output logic [2:0]  weekday_out_o,
  output logic        is_holiday_o,
  output logic        in_range_o,
  output logic        load_rejected_o
);

  // current date
  logic [10:0] cur_year_q;
  logic [3:0]  cur_month_q;
  logic [4:0]  cur_day_q;
  logic [2:0]  cur_wd_q;

  // latched load beat
  logic [11:0] ld_year_q;
  logic [3:0]  ld_month_q;
  logic [4:0]  ld_day_q;
  logic        rej_q;

  // weekday walk
  logic [2:0]  acc_q;
  logic [3:0]  yoff_q;
  logic [3:0]  ytgt_q;
  logic [3:0]  mcnt_q;

  logic        out_valid_q;
  logic [10:0] year_out_q;
  logic [3:0]  month_out_q;
  logic [4:0]  day_out_q;
  logic [2:0]  wd_out_q;
  logic        hol_out_q;
  logic        rng_out_q;
  logic        rej_out_q;

  logic        ld_leap;
  logic        load_ok;
  logic        cur_in_range;
  logic [4:0]  cur_len;
  logic [11:0] yoff_full;

  assign ld_leap      = (ld_year_q[1:0] == 2'b11);
  assign cur_in_range = (cur_year_q <= LAST_YEAR);
  assign cur_len      = month_len(cur_year_q[1:0] == 2'b11, cur_month_q);
  assign yoff_full    = ld_year_q - {1'b0, FIRST_YEAR};

  assign load_ok = (ld_year_q >= {1'b0, FIRST_YEAR}) && (ld_year_q <= {1'b0, LAST_YEAR}) &&
                   (ld_month_q >= 4'd1) && (ld_month_q <= LAST_MONTH) &&
                   (ld_day_q >= 5'd1) && (ld_day_q <= month_len(ld_leap, ld_month_q));

  assign sts_o.action     = action_i;
  assign sts_o.load_ok    = load_ok;
  assign sts_o.year_done  = (yoff_q == ytgt_q);
  assign sts_o.month_done = (mcnt_q == ld_month_q);
  assign sts_o.out_busy   = out_valid_q && out_stall_i;

  // load beat and walk registers, payload only
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      ld_year_q  <= load_year_i;
      ld_month_q <= load_month_i;
      ld_day_q   <= load_day_i;
    end
    if (cmd_i.check) begin
      acc_q  <= mod7_small(ld_day_q - 5'd1);
      yoff_q <= '0;
      ytgt_q <= yoff_full[3:0];
      mcnt_q <= 4'd1;
    end else if (cmd_i.year_step) begin
      // offset 0 mod 4 is a 366-day year
      acc_q  <= add_mod7(acc_q, (yoff_q[1:0] == 2'b00) ? 2'd2 : 2'd1);
      yoff_q <= yoff_q + 4'd1;
    end else if (cmd_i.month_step) begin
      acc_q  <= add_mod7(acc_q, 2'(month_len(ld_leap, mcnt_q) - 5'd28));
      mcnt_q <= mcnt_q + 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_year_q  <= FIRST_YEAR;
      cur_month_q <= 4'd1;
      cur_day_q   <= 5'd1;
      cur_wd_q    <= 3'd0;
      rej_q       <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        rej_q <= 1'b0;
      end
      if (cmd_i.check) begin
        rej_q <= !load_ok;
      end
      if (cmd_i.adv && cur_in_range) begin
        if (cur_day_q < cur_len) begin
          cur_day_q <= cur_day_q + 5'd1;
        end else begin
          cur_day_q <= 5'd1;
          if (cur_month_q >= LAST_MONTH) begin
            cur_month_q <= 4'd1;
            cur_year_q  <= cur_year_q + 11'd1;
          end else begin
            cur_month_q <= cur_month_q + 4'd1;
          end
        end
        cur_wd_q <= add_mod7(cur_wd_q, 2'd1);
      end
      if (cmd_i.commit) begin
        cur_year_q  <= ld_year_q[10:0];
        cur_month_q <= ld_month_q;
        cur_day_q   <= ld_day_q;
        cur_wd_q    <= acc_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      year_out_q  <= cur_year_q;
      month_out_q <= cur_month_q;
      day_out_q   <= cur_day_q;
      wd_out_q    <= cur_wd_q;
      hol_out_q   <= (cur_wd_q == WD_THURSDAY) || (cur_wd_q == WD_FRIDAY) ||
                     fixed_holiday(cur_month_q, cur_day_q);
      rng_out_q   <= cur_in_range;
      rej_out_q   <= rej_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign year_out_o      = year_out_q;
  assign month_out_o     = month_out_q;
  assign day_out_o       = day_out_q;
  assign weekday_out_o   = wd_out_q;
  assign is_holiday_o    = hol_out_q;
  assign in_range_o      = rng_out_q;
  assign load_rejected_o = rej_out_q;

`ifndef ASSERT_OFF
  a_wd_legal: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_wd_q != 3'd7)
    else $error("weekday out of range");

  a_year_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cur_year_q >= FIRST_YEAR && cur_year_q <= PAST_YEAR)
    else $error("year left the supported span");

  a_saturate: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.adv && !cur_in_range |=> $stable(cur_year_q) && $stable(cur_day_q) &&
    $stable(cur_wd_q))
    else $error("date moved past the end of the range");

  a_reject_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.check && !load_ok |=> $stable(cur_year_q) && $stable(cur_month_q) &&
    $stable(cur_day_q) && rej_q)
    else $error("rejected load changed the date");
`endif

endmodule

// ----- tb/testbench.sv -----
module testbench;
  import shd_pkg::*;

  // beat kinds on the input channel
  localparam logic ACT_ADVANCE = 1'b0;
  localparam logic ACT_LOAD    = 1'b1;

  // slowest correct run: about 1925 beats, each with the longest load walk in the block,
  // the longest sender gap and the longest receiver stall; the limit is several times that
  localparam int unsigned CYCLE_LIMIT   = 1_000_000;
  // longest load walk plus margin, waited out at the end
  localparam int unsigned SETTLE_CYCLES = 32;

  typedef struct packed {
    logic [10:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic        holiday;
    logic        in_range;
    logic        rejected;
  } date_report_t;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic        action_i      = ACT_ADVANCE;
  logic [11:0] load_year_i   = '0;
  logic [3:0]  load_month_i  = '0;
  logic [4:0]  load_day_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [10:0] year_out_o;
  logic [3:0]  month_out_o;
  logic [4:0]  day_out_o;
  logic [2:0]  weekday_out_o;
  logic        is_holiday_o;
  logic        in_range_o;
  logic        load_rejected_o;

  // calendar as the block should hold it
  logic [10:0] cal_year    = FIRST_YEAR;
  logic [3:0]  cal_month   = 4'd1;
  logic [4:0]  cal_day     = 5'd1;
  logic [2:0]  cal_weekday = 3'd0;

  date_report_t pending_reports[$];
  int unsigned  error_count  = 0;
  int unsigned  beats_sent   = 0;
  int unsigned  cycle_count  = 0;
  int unsigned  stall_left   = 0;
  bit           send_idle_on = 1'b0;
  bit           recv_idle_on = 1'b0;

  solar_hijri_date_counter i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .action_i       (action_i),
    .load_year_i    (load_year_i),
    .load_month_i   (load_month_i),
    .load_day_i     (load_day_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .year_out_o     (year_out_o),
    .month_out_o    (month_out_o),
    .day_out_o      (day_out_o),
    .weekday_out_o  (weekday_out_o),
    .is_holiday_o   (is_holiday_o),
    .in_range_o     (in_range_o),
    .load_rejected_o(load_rejected_o)
  );

  always #5 clk_i = ~clk_i;

  // hard stop in case the block hangs
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_reports.size());
      $display("testbench: errors");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // calendar arithmetic
  // ---------------------------------------------------------------------------

  // a year of 366 days is one with year mod 4 equal to 3
  function automatic bit long_year(int unsigned y);
    return (y % 4) == 3;
  endfunction

  function automatic int unsigned days_in(int unsigned y, int unsigned m);
    if (m <= 6) return 31;
    if (m <= 11) return 30;
    return long_year(y) ? 30 : 29;
  endfunction

  // count days from the first day of the range, which falls on a sunday
  function automatic logic [2:0] weekday_since_epoch(int unsigned y, int unsigned m,
                                                     int unsigned d);
    int unsigned total;
    total = 0;
    for (int unsigned yy = FIRST_YEAR; yy < y; yy++) total += long_year(yy) ? 366 : 365;
    for (int unsigned mm = 1; mm < m; mm++) total += days_in(y, mm);
    total += d - 1;
    return 3'(total % 7);
  endfunction

  // new year, nowruz tail, spring and winter days, year end
  function automatic bit fixed_date_off(logic [3:0] m, logic [4:0] d);
    return (m == 4'd1 && (d <= 5'd4 || d == 5'd12 || d == 5'd13)) ||
           (m == 4'd3 && (d == 5'd14 || d == 5'd15)) ||
           (m == 4'd11 && d == 5'd22) ||
           (m == 4'd12 && d >= 5'd27);
  endfunction

  // apply one accepted beat to the calendar and queue the report it yields
  task automatic predict_date_step(logic act, logic [11:0] ly, logic [3:0] lm, logic [4:0] ld);
    date_report_t r;
    bit           ok;
    r.rejected = 1'b0;
    if (act == ACT_ADVANCE) begin
      // once past the range the date sticks
      if (cal_year <= LAST_YEAR) begin
        if (cal_day < days_in(cal_year, cal_month)) begin
          cal_day++;
        end else begin
          cal_day = 5'd1;
          if (cal_month >= LAST_MONTH) begin
            cal_month = 4'd1;
            cal_year++;
          end else begin
            cal_month++;
          end
        end
        cal_weekday = (cal_weekday == 3'd6) ? 3'd0 : cal_weekday + 3'd1;
      end
    end else begin
      ok = ly >= FIRST_YEAR && ly <= LAST_YEAR && lm >= 4'd1 && lm <= LAST_MONTH &&
           ld >= 5'd1 && ld <= days_in(ly, lm);
      if (ok) begin
        cal_year    = 11'(ly);
        cal_month   = lm;
        cal_day     = ld;
        cal_weekday = weekday_since_epoch(ly, lm, ld);
      end else begin
        r.rejected = 1'b1;
      end
    end
    r.year     = cal_year;
    r.month    = cal_month;
    r.day      = cal_day;
    r.weekday  = cal_weekday;
    r.holiday  = cal_weekday == WD_THURSDAY || cal_weekday == WD_FRIDAY ||
                 fixed_date_off(cal_month, cal_day);
    r.in_range = cal_year >= FIRST_YEAR && cal_year <= LAST_YEAR;
    pending_reports.push_back(r);
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall bursts and the checker
  // ---------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else if (recv_idle_on && $urandom_range(0, 4) == 0) begin
      // start a stall burst, this cycle included; stall_left holds how many more stalled cycles follow
      out_stall_i <= 1'b1;
      stall_left = $urandom_range(0, 15);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  task automatic check_field(string name, logic [11:0] want, logic [11:0] seen);
    if (seen !== want) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, seen);
      error_count++;
    end
  endtask

  // every result beat is matched against the oldest queued report
  always @(posedge clk_i) begin : check_results
    date_report_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_reports.size() == 0) begin
        $display("%0t: result %0d-%0d-%0d with none expected", $time,
                 year_out_o, month_out_o, day_out_o);
        error_count++;
      end else begin
        want = pending_reports.pop_front();
        check_field("year",      12'(want.year),     12'(year_out_o));
        check_field("month",     12'(want.month),    12'(month_out_o));
        check_field("day",       12'(want.day),      12'(day_out_o));
        check_field("weekday",   12'(want.weekday),  12'(weekday_out_o));
        check_field("holiday",   12'(want.holiday),  12'(is_holiday_o));
        check_field("in_range",  12'(want.in_range), 12'(in_range_o));
        check_field("rejected",  12'(want.rejected), 12'(load_rejected_o));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // input side
  // ---------------------------------------------------------------------------

  // one input beat; valid is only dropped for a gap, so back to back beats keep it high
  task automatic send_beat(logic act, logic [11:0] ly, logic [3:0] lm, logic [4:0] ld);
    if (send_idle_on && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    action_i     <= act;
    load_year_i  <= ly;
    load_month_i <= lm;
    load_day_i   <= ld;
    do @(posedge clk_i); while (in_stall_o);
    beats_sent++;
    predict_date_step(act, ly, lm, ld);
  endtask

  // load fields are don't care on an advance, so fill them with noise
  task automatic advance_day();
    send_beat(ACT_ADVANCE, 12'($urandom), 4'($urandom), 5'($urandom));
  endtask

  task automatic pause_until_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_reports.size() != 0);
  endtask

  // valid date, leaning to first and last days of a month
  task automatic pick_valid_date(output logic [11:0] y, output logic [3:0] m,
                                 output logic [4:0] d);
    y = 12'($urandom_range(FIRST_YEAR, LAST_YEAR));
    m = 4'($urandom_range(1, 12));
    case ($urandom_range(0, 3))
      0: d = 5'(days_in(y, m));
      1: d = 5'd1;
      default: d = 5'($urandom_range(1, days_in(y, m)));
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // a rejected load first shows the reset date, then one step from it
  task automatic test_reset_date();
    send_beat(ACT_LOAD, 12'd0, 4'd0, 5'd0);
    advance_day();
  endtask

  // field extremes and each way a load can fail
  task automatic test_load_rejects();
    send_beat(ACT_LOAD, 12'd4095, 4'd15, 5'd31);
    send_beat(ACT_LOAD, 12'(FIRST_YEAR - 1), 4'd1, 5'd1);
    send_beat(ACT_LOAD, 12'(LAST_YEAR + 1), 4'd1, 5'd1);
    send_beat(ACT_LOAD, 12'(FIRST_YEAR), 4'd0, 5'd1);
    send_beat(ACT_LOAD, 12'(FIRST_YEAR), 4'd13, 5'd1);
    send_beat(ACT_LOAD, 12'(FIRST_YEAR), 4'd1, 5'd0);
    send_beat(ACT_LOAD, 12'd1398, 4'd7, 5'd31);
    // short final month in a 365 day year
    send_beat(ACT_LOAD, 12'd1396, 4'd12, 5'd30);
    send_beat(ACT_LOAD, 12'd1401, 4'd2, 5'd31);
  endtask

  // month rollover at the 31/30 boundary and both kinds of year end
  task automatic test_month_year_ends();
    send_beat(ACT_LOAD, 12'd1398, 4'd6, 5'd31);
    advance_day();
    send_beat(ACT_LOAD, 12'(FIRST_YEAR), 4'd12, 5'd30);
    advance_day();
    send_beat(ACT_LOAD, 12'd1396, 4'd12, 5'd29);
    advance_day();
  endtask

  // walk off the top of the range, stay there, then get back in
  task automatic test_range_end();
    send_beat(ACT_LOAD, 12'(LAST_YEAR), LAST_MONTH, 5'd29);
    advance_day();
    advance_day();
    advance_day();
    send_beat(ACT_LOAD, 12'(LAST_YEAR), 4'd12, 5'd31);
    send_beat(ACT_LOAD, 12'd1399, 4'd3, 5'd14);
  endtask

  // mostly a valid load followed by a run of days, with bad loads and noise mixed in
  task automatic test_random_walks(int unsigned beats, bit allow_idle);
    int unsigned stop_at;
    int unsigned run;
    logic [11:0] y;
    logic [3:0]  m;
    logic [4:0]  d;
    stop_at = beats_sent + beats;
    while (beats_sent < stop_at) begin
      send_idle_on = allow_idle && $urandom_range(0, 3) != 0;
      recv_idle_on = allow_idle && $urandom_range(0, 3) != 0;
      case ($urandom_range(0, 9))
        6: begin
          // last days of the range, a run that can go past the end
          send_beat(ACT_LOAD, 12'(LAST_YEAR), LAST_MONTH, 5'($urandom_range(20, 30)));
          run = $urandom_range(5, 20);
        end
        7, 8: begin
          pick_valid_date(y, m, d);
          case ($urandom_range(0, 3))
            0: y = 12'($urandom);
            1: y = $urandom_range(0, 1) ? 12'(FIRST_YEAR - 1) : 12'(LAST_YEAR + 1);
            2: m = $urandom_range(0, 1) ? 4'd0 : 4'($urandom_range(13, 15));
            default: d = $urandom_range(0, 1) ? 5'd0 : 5'(days_in(y, m) + 1);
          endcase
          send_beat(ACT_LOAD, y, m, d);
          run = $urandom_range(0, 4);
        end
        9: begin
          send_beat(1'($urandom), 12'($urandom), 4'($urandom), 5'($urandom));
          run = 0;
        end
        default: begin
          pick_valid_date(y, m, d);
          send_beat(ACT_LOAD, y, m, d);
          run = $urandom_range(1, 40);
        end
      endcase
      repeat (run) advance_day();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_on = 1'b1;
    recv_idle_on = 1'b1;
    test_reset_date();
    test_load_rejects();
    test_month_year_ends();
    test_range_end();

    test_random_walks(950, 1'b1);
    // let the block run dry before carrying on
    pause_until_drained();
    test_random_walks(750, 1'b1);
    // closing stretch at full rate
    test_random_walks(200, 1'b0);
    in_valid_i <= 1'b0;

    while (pending_reports.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
